>>> sv/sbsm_pkg.sv
`timescale 1ns / 1ps

package sbsm_pkg;

	// Width of the interrupt tick counter; 16 to 32.
	localparam int CNT_W = 30;
	localparam logic [31:0] CNT_MAX = 32'((64'd1 << CNT_W) - 64'd1);

	// Value that the control register takes at reset and that a bit-7 write ORs into it.
	localparam logic [4:0] CTRL_RESET = 5'h0C;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	typedef enum logic [2:0] {
		REG_PRG_COUNT    = 3'd0,
		REG_CHR_COUNT    = 3'd1,
		REG_SRAM_EN      = 3'd2,
		REG_INIT_VMIRROR = 3'd3,
		REG_IRQ_LIMIT    = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		MIRROR_ONE   = 2'd0,
		MIRROR_VERT  = 2'd1,
		MIRROR_HORIZ = 2'd2
	} mirror_t;

	typedef struct packed {
		logic [4:0] r0;
		logic [4:0] r1;
		logic [4:0] r2;
		logic [4:0] r3;
	} map_regs_t;

	typedef struct packed {
		mirror_t    mirror;
		logic [4:0] chr_lo;
		logic [4:0] chr_hi;
		logic [7:0] prg_lo;
		logic [7:0] prg_hi;
		logic       irq_off;
	} bank_map_t;

endpackage

>>> sv/sbsm_bank_calc.sv
`timescale 1ns / 1ps

// Bank map derived from the four mapper registers and the cart size.
module sbsm_bank_calc (
	input  sbsm_pkg::map_regs_t regs,
	input  logic [7:0]          prg_count,
	input  logic [7:0]          chr_count,
	output sbsm_pkg::bank_map_t map
);

	typedef enum logic [1:0] {
		SIZE_SMALL = 2'd0,
		SIZE_MID   = 2'd1,
		SIZE_LARGE = 2'd2
	} size_t;

	size_t      size;
	logic [3:0] chr_mask;
	logic [3:0] chr_bank;
	logic [7:0] outer;
	logic [7:0] bank32;
	logic [7:0] bank16;

	always_comb begin
		// Only the low four bits of the masks ever matter; the 4 KB mask is all ones.
		if (chr_count == 8'd0 || chr_count[0]) begin
			chr_mask = 4'd7;
		end else begin
			chr_mask = 4'd15;
		end
		chr_bank = regs.r1[3:0] & chr_mask;

		if (regs.r0[1]) begin
			map.mirror = regs.r0[0] ? sbsm_pkg::MIRROR_HORIZ : sbsm_pkg::MIRROR_VERT;
		end else begin
			map.mirror = sbsm_pkg::MIRROR_ONE;
		end

		if (!regs.r0[4]) begin
			map.chr_lo = {chr_bank, 1'b0};
			map.chr_hi = {chr_bank, 1'b1};
		end else begin
			map.chr_lo = {1'b0, regs.r1[3:0]};
			map.chr_hi = {1'b0, regs.r2[3:0]};
		end

		if (prg_count < 8'd32) begin
			size = SIZE_SMALL;
		end else if (prg_count < 8'd64) begin
			size = SIZE_MID;
		end else begin
			size = SIZE_LARGE;
		end

		// outer 256 KB select in 16 KB units
		case (size)
			SIZE_MID: begin
				outer = regs.r1[4] ? 8'd16 : 8'd0;
			end
			SIZE_LARGE: begin
				if (regs.r0[4]) begin
					outer = {2'b00, regs.r2[4:3] | {1'b0, regs.r1[4]}, 4'b0000};
				end else begin
					outer = regs.r1[4] ? 8'd32 : 8'd0;
				end
			end
			default: begin
				outer = 8'd0;
			end
		endcase

		bank32 = {4'b0000, regs.r3[3:1], 1'b0};
		bank16 = {4'b0000, regs.r3[3:0]};

		if (!regs.r0[3]) begin
			map.prg_lo = outer + bank32;
			map.prg_hi = outer + bank32 + 8'd1;
		end else if (regs.r0[2]) begin
			map.prg_lo = outer + bank16;
			map.prg_hi = (size == SIZE_SMALL) ? (prg_count - 8'd1) : (outer + 8'd15);
		end else begin
			map.prg_hi = outer + bank16;
			map.prg_lo = (size == SIZE_SMALL) ? 8'd0 : outer;
		end

		map.irq_off = regs.r0[4];
	end

endmodule

>>> sv/serial_bank_switch_mapper.sv
`timescale 1ns / 1ps

// Serial bank-switch cartridge mapper. Each input item is a CPU write
// (command 0) or one CPU-cycle tick (command 1); each gives exactly one
// result item carrying the bank map and IRQ level after that item, plus
// the save RAM write strobe, offset and byte. The block takes one item
// per clock unless the result register stalls: an item is registered on
// entry, processed by one level of shift/mask/add logic and lands in the
// result register once that register is free or is being taken. The
// state update of the serial latch, mapper registers and IRQ counter
// is done in the same logic, between the input and result registers,
// which sets the one-item-per-clock rate. New items keep flowing while
// the result register is full only if the sink takes the result in the
// same cycle. Configuration goes through the APB port (registers at
// 4*i: bank counts, save RAM enable, initial mirroring, IRQ limit) and
// is to be written only while the block is idle.
module serial_bank_switch_mapper (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,

	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  logic        command,
	input  logic [15:0] address,
	input  logic [7:0]  value,
	input  logic        write_phase_ok,

	output logic        res_valid,
	input  logic        res_ready,
	output logic [1:0]  mirroring,
	output logic [4:0]  chr_low_base,
	output logic [4:0]  chr_high_base,
	output logic [7:0]  prg_low_base,
	output logic [7:0]  prg_high_base,
	output logic        irq_pending,
	output logic        sram_write,
	output logic [12:0] sram_address,
	output logic [7:0]  sram_data
);

	// configuration registers
	logic [7:0]  prg_count_q;
	logic [7:0]  chr_count_q;
	logic        sram_en_q;
	logic        init_vmirror_q;
	logic [29:0] irq_limit_q;

	// mapper state
	logic [4:0]              latch_q;
	logic [2:0]              count_q;
	sbsm_pkg::map_regs_t     regs_q;
	sbsm_pkg::mirror_t       mirror_q;
	logic [4:0]              chr_lo_q;
	logic [4:0]              chr_hi_q;
	logic [7:0]              prg_lo_q;
	logic [7:0]              prg_hi_q;
	logic                    irq_en_q;
	logic [sbsm_pkg::CNT_W-1:0] irq_count_q;
	logic                    irq_flag_q;
	logic                    loaded_q;

	// input stage
	logic        valid_s1;
	logic        command_s1;
	logic [15:0] address_s1;
	logic [7:0]  value_s1;
	logic        phase_s1;

	// result register
	logic        res_valid_q;
	logic [1:0]  mirroring_q;
	logic [4:0]  chr_low_q;
	logic [4:0]  chr_high_q;
	logic [7:0]  prg_low_q;
	logic [7:0]  prg_high_q;
	logic        irq_pending_q;
	logic        sram_write_q;
	logic [12:0] sram_address_q;
	logic [7:0]  sram_data_q;

	logic advance;
	logic cfg_wr;
	sbsm_pkg::reg_idx_t cfg_idx;

	// item processing
	logic                is_sram;
	logic                is_map;
	logic                do_load;
	logic [4:0]          latch_nx;
	logic [2:0]          count_nx;
	sbsm_pkg::map_regs_t regs_nx;
	sbsm_pkg::bank_map_t map;
	logic                tick;
	logic [31:0]         cnt32;
	logic [31:0]         lim32;
	logic [31:0]         cap32;
	logic [31:0]         cnt_nx32;
	logic                flag_nx;

	assign advance   = valid_s1 && (!res_valid_q || res_ready);
	assign cmd_ready = !valid_s1 || advance;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = sbsm_pkg::reg_idx_t'(paddr[4:2]);

	always_comb begin
		case (cfg_idx)
			sbsm_pkg::REG_PRG_COUNT:    prdata = {24'd0, prg_count_q};
			sbsm_pkg::REG_CHR_COUNT:    prdata = {24'd0, chr_count_q};
			sbsm_pkg::REG_SRAM_EN:      prdata = {31'd0, sram_en_q};
			sbsm_pkg::REG_INIT_VMIRROR: prdata = {31'd0, init_vmirror_q};
			sbsm_pkg::REG_IRQ_LIMIT:    prdata = {2'd0, irq_limit_q};
			default:                    prdata = 32'd0;
		endcase
	end

	always_comb begin
		is_sram = (command_s1 == sbsm_pkg::CMD_WRITE) && (address_s1[15:13] == 3'b011);
		is_map  = (command_s1 == sbsm_pkg::CMD_WRITE) && address_s1[15] && phase_s1;
		tick    = (command_s1 == sbsm_pkg::CMD_TICK) && irq_en_q;

		latch_nx = latch_q;
		count_nx = count_q;
		regs_nx  = regs_q;
		do_load  = 1'b0;
		if (is_map) begin
			if (value_s1[7]) begin
				// bit 7: force 16 KB mode with fixed last bank, drop the latch
				regs_nx.r0 = regs_q.r0 | sbsm_pkg::CTRL_RESET;
				do_load    = 1'b1;
			end else begin
				latch_nx[count_q] = value_s1[0];
				count_nx          = count_q + 3'd1;
				if (count_nx == 3'd5) begin
					do_load = 1'b1;
					case (address_s1[14:13])
						2'd0:    regs_nx.r0 = latch_nx;
						2'd1:    regs_nx.r1 = latch_nx;
						2'd2:    regs_nx.r2 = latch_nx;
						default: regs_nx.r3 = latch_nx;
					endcase
				end
			end
			if (do_load) begin
				latch_nx = 5'd0;
				count_nx = 3'd0;
			end
		end

		// counter saturates at the smaller of the limit and its own range
		cnt32    = 32'(irq_count_q);
		lim32    = {2'b00, irq_limit_q};
		cap32    = (lim32 < sbsm_pkg::CNT_MAX) ? lim32 : sbsm_pkg::CNT_MAX;
		cnt_nx32 = (cnt32 < cap32) ? (cnt32 + 32'd1) : cnt32;
		flag_nx  = irq_flag_q || (cnt_nx32 >= lim32);
	end

	sbsm_bank_calc u_bank_calc (
		.regs      (regs_nx),
		.prg_count (prg_count_q),
		.chr_count (chr_count_q),
		.map       (map)
	);

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid) begin
			command_s1 <= command;
			address_s1 <= address;
			value_s1   <= value;
			phase_s1   <= write_phase_ok;
		end
	end

	// configuration and mapper state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_count_q    <= 8'd2;
			chr_count_q    <= 8'd0;
			sram_en_q      <= 1'b0;
			init_vmirror_q <= 1'b0;
			irq_limit_q    <= 30'd671088640;
			latch_q        <= 5'd0;
			count_q        <= 3'd0;
			regs_q         <= '{r0: sbsm_pkg::CTRL_RESET, r1: 5'd0, r2: 5'd0, r3: 5'd0};
			mirror_q       <= sbsm_pkg::MIRROR_HORIZ;
			chr_lo_q       <= 5'd0;
			chr_hi_q       <= 5'd1;
			prg_lo_q       <= 8'd0;
			prg_hi_q       <= 8'd1;
			irq_en_q       <= 1'b0;
			irq_count_q    <= '0;
			irq_flag_q     <= 1'b0;
			loaded_q       <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (cfg_idx)
					sbsm_pkg::REG_PRG_COUNT: begin
						prg_count_q <= pwdata[7:0];
						// fixed last bank follows the count until the first load
						if (!loaded_q) begin
							prg_hi_q <= pwdata[7:0] - 8'd1;
						end
					end
					sbsm_pkg::REG_CHR_COUNT: begin
						chr_count_q <= pwdata[7:0];
					end
					sbsm_pkg::REG_SRAM_EN: begin
						sram_en_q <= pwdata[0];
					end
					sbsm_pkg::REG_INIT_VMIRROR: begin
						init_vmirror_q <= pwdata[0];
						if (!loaded_q) begin
							mirror_q <= pwdata[0] ? sbsm_pkg::MIRROR_VERT
							                      : sbsm_pkg::MIRROR_HORIZ;
						end
					end
					sbsm_pkg::REG_IRQ_LIMIT: begin
						irq_limit_q <= pwdata[29:0];
					end
					default: begin
					end
				endcase
			end
			if (advance) begin
				latch_q <= latch_nx;
				count_q <= count_nx;
				regs_q  <= regs_nx;
				if (tick) begin
					irq_count_q <= sbsm_pkg::CNT_W'(cnt_nx32);
					irq_flag_q  <= flag_nx;
				end
				if (do_load) begin
					loaded_q <= 1'b1;
					mirror_q <= map.mirror;
					chr_lo_q <= map.chr_lo;
					chr_hi_q <= map.chr_hi;
					prg_lo_q <= map.prg_lo;
					prg_hi_q <= map.prg_hi;
					irq_en_q <= !map.irq_off;
					if (map.irq_off) begin
						irq_count_q <= '0;
						irq_flag_q  <= 1'b0;
					end
				end
			end
		end
	end

	// result register: state after this item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (do_load) begin
				mirroring_q   <= map.mirror;
				chr_low_q     <= map.chr_lo;
				chr_high_q    <= map.chr_hi;
				prg_low_q     <= map.prg_lo;
				prg_high_q    <= map.prg_hi;
				irq_pending_q <= map.irq_off ? 1'b0 : irq_flag_q;
			end else begin
				mirroring_q   <= mirror_q;
				chr_low_q     <= chr_lo_q;
				chr_high_q    <= chr_hi_q;
				prg_low_q     <= prg_lo_q;
				prg_high_q    <= prg_hi_q;
				irq_pending_q <= tick ? flag_nx : irq_flag_q;
			end
			sram_write_q   <= is_sram && sram_en_q;
			sram_address_q <= (is_sram && sram_en_q) ? address_s1[12:0] : 13'd0;
			sram_data_q    <= (is_sram && sram_en_q) ? value_s1 : 8'd0;
		end
	end

	assign res_valid     = res_valid_q;
	assign mirroring     = mirroring_q;
	assign chr_low_base  = chr_low_q;
	assign chr_high_base = chr_high_q;
	assign prg_low_base  = prg_low_q;
	assign prg_high_base = prg_high_q;
	assign irq_pending   = irq_pending_q;
	assign sram_write    = sram_write_q;
	assign sram_address  = sram_address_q;
	assign sram_data     = sram_data_q;

endmodule
